// ===== rtl/swac_pkg.sv =====
// Shared types, codes and defaults for the sweep waveform column renderer.
// Used by every module in rtl/; depends on nothing.
package swac_pkg;

    localparam int LIMIT_ENTRIES_DEF = 8;
    localparam int FRAME_SAMPLES_DEF = 50;

    // Divider runs one quotient bit per cycle, MSB first.
    localparam int DIV_BITS = 11;
    localparam int DIV_BIT_W = 4;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_LIMIT  = 2'd2;

    localparam logic [1:0] DRAW_ERASE  = 2'd0;
    localparam logic [1:0] DRAW_DIM    = 2'd1;
    localparam logic [1:0] DRAW_BRIGHT = 2'd2;
    localparam logic [1:0] DRAW_CLEAR  = 2'd3;

    localparam logic [1:0] MODE_FLOOR = 2'd0;
    localparam logic [1:0] MODE_ZERO  = 2'd1;
    localparam logic [1:0] MODE_SYM   = 2'd2;

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_PLOT_HEIGHT = 3'd2;
    localparam logic [2:0] REG_SWEEP_WIDTH = 3'd3;
    localparam logic [2:0] REG_RANGE_MODE  = 3'd4;
    localparam logic [2:0] REG_NEG_FLOOR   = 3'd5;
    localparam logic [2:0] REG_LIMIT_COUNT = 3'd6;

    // Divider operand selects, in run order.
    localparam logic [1:0] SEL_MOD    = 2'd0;
    localparam logic [1:0] SEL_NEGPIX = 2'd1;
    localparam logic [1:0] SEL_MAXPIX = 2'd2;
    localparam logic [1:0] SEL_MINPIX = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] sample_value;
        logic [2:0]         limit_index;
        logic [14:0]        limit_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         draw_kind;
        logic signed [11:0] x_start;
        logic signed [15:0] y_start;
        logic signed [11:0] x_end;
        logic signed [15:0] y_end;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic                 accept;
        logic                 div_load;
        logic                 div_step;
        logic                 div_store;
        logic [1:0]           div_sel;
        logic [DIV_BIT_W-1:0] div_bit;
        logic                 walk_init;
        logic                 walk_step;
        logic                 range_update;
        logic                 out_load;
        logic [1:0]           emit_idx;
    } swac_cmd_t;

    typedef struct packed {
        logic       is_tick;
        logic       sweep_end;
        logic       walk_done;
        logic [1:0] last_idx;
    } swac_status_t;

endpackage

// ===== rtl/swac_datapath.sv =====
// Datapath: config registers, frame/sweep state, limit table, shared
// restoring divider and result register. Depends on swac_pkg.
module swac_datapath
    import swac_pkg::*;
#(
    parameter int LIMIT_ENTRIES = LIMIT_ENTRIES_DEF,
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  in_item_t     in_data,
    input  logic         cfg_valid,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  swac_cmd_t    cmd,
    output swac_status_t status,
    output out_item_t    out_data
);

    localparam int LIDX_W = (LIMIT_ENTRIES > 1) ? $clog2(LIMIT_ENTRIES) : 1;

    logic [9:0]         origin_x_reg, origin_y_reg, plot_height_reg;
    logic [10:0]        sweep_width_reg;
    logic [1:0]         range_mode_reg;
    logic signed [15:0] neg_floor_reg;
    logic [3:0]         limit_count_reg;

    logic signed [15:0] frame_max_reg, frame_min_reg, sweep_max_reg, sweep_min_reg;
    logic [5:0]         frame_count_reg;
    logic [9:0]         column_reg;
    logic signed [15:0] range_top_reg, range_bottom_reg;
    logic [14:0]        limit_table [LIMIT_ENTRIES];

    logic signed [15:0] cmax_reg, cmin_reg;
    logic [10:0]        col_inc_reg;
    logic [11:0]        xc_reg, xe_reg;
    logic               sweep_end_reg, changed_reg;
    logic [26:0]        rem_reg;
    logic [16:0]        den_reg;
    logic               qneg_reg;
    logic [DIV_BITS-1:0] q_reg;
    logic signed [11:0] negpix_reg, maxpix_reg, minpix_reg;
    logic [LIDX_W-1:0]  walk_idx_reg;
    logic [14:0]        chosen_reg;
    out_item_t          out_reg;

    // tick entry values
    logic signed [15:0] cmax, cmin, cmax_c, cmin_c, cmax_k, cmin_k;
    logic [10:0]        width_eff;
    logic [16:0]        top_abs, bot_abs, sum;
    logic [16:0]        cmax_abs, cmin_abs;
    logic [26:0]        div_num;
    logic [16:0]        div_den;
    logic               div_neg;
    logic [27:0]        shifted;
    logic [11:0]        q_signed;
    logic [4:0]         cnt_eff;
    logic [14:0]        entry;
    logic signed [17:0] peak;
    logic [16:0]        smax_abs, smin_abs;
    logic signed [15:0] zero, y_min, y_max;
    logic [LIDX_W+2:0]  wr_idx_ext;
    out_item_t          item;

    always_comb
    begin
        cmax = (frame_count_reg != 6'd0) ? frame_max_reg : 16'sd0;
        cmin = (frame_count_reg != 6'd0) ? frame_min_reg : 16'sd0;
        cmax_c = (cmax > range_top_reg) ? range_top_reg : cmax;
        cmin_c = (cmin > range_top_reg) ? range_top_reg : cmin;
        cmax_k = (cmax_c < range_bottom_reg) ? range_bottom_reg : cmax_c;
        cmin_k = (cmin_c < range_bottom_reg) ? range_bottom_reg : cmin_c;
        if (sweep_width_reg == 11'd0)
            width_eff = 11'd1;
        else if (sweep_width_reg > 11'd1024)
            width_eff = 11'd1024;
        else
            width_eff = sweep_width_reg;
    end

    assign top_abs  = range_top_reg[15] ? 17'(-{range_top_reg[15], range_top_reg})
                                        : {1'b0, range_top_reg};
    assign bot_abs  = range_bottom_reg[15]
                      ? 17'(-{range_bottom_reg[15], range_bottom_reg})
                      : {1'b0, range_bottom_reg};
    assign sum      = top_abs + bot_abs;
    assign cmax_abs = cmax_reg[15] ? 17'(-{cmax_reg[15], cmax_reg}) : {1'b0, cmax_reg};
    assign cmin_abs = cmin_reg[15] ? 17'(-{cmin_reg[15], cmin_reg}) : {1'b0, cmin_reg};

    always_comb
    begin
        case (cmd.div_sel)
            SEL_MOD:
            begin
                div_num = {16'd0, col_inc_reg};
                div_den = {6'd0, width_eff};
                div_neg = 1'b0;
            end
            SEL_NEGPIX:
            begin
                div_num = 27'(plot_height_reg * bot_abs);
                div_den = sum;
                div_neg = 1'b0;
            end
            SEL_MAXPIX:
            begin
                div_num = 27'(plot_height_reg * cmax_abs);
                div_den = sum;
                div_neg = cmax_reg[15];
            end
            default:
            begin
                div_num = 27'(plot_height_reg * cmin_abs);
                div_den = sum;
                div_neg = cmin_reg[15];
            end
        endcase
    end

    assign shifted  = {11'd0, den_reg} << cmd.div_bit;
    assign q_signed = (sum == 17'd0) ? 12'sd0
                      : (qneg_reg ? 12'(-{1'b0, q_reg}) : {1'b0, q_reg});

    // limit walk
    assign cnt_eff  = (32'(limit_count_reg) > LIMIT_ENTRIES) ? 5'(LIMIT_ENTRIES)
                                                             : {1'b0, limit_count_reg};
    assign entry    = limit_table[walk_idx_reg];
    assign smax_abs = sweep_max_reg[15] ? 17'(-{sweep_max_reg[15], sweep_max_reg})
                                        : {1'b0, sweep_max_reg};
    assign smin_abs = sweep_min_reg[15] ? 17'(-{sweep_min_reg[15], sweep_min_reg})
                                        : {1'b0, sweep_min_reg};

    always_comb
    begin
        if (range_mode_reg == MODE_SYM)
            peak = (smax_abs > smin_abs) ? $signed({1'b0, smax_abs})
                                         : $signed({1'b0, smin_abs});
        else
            peak = 18'(sweep_max_reg);
    end

    assign status.is_tick   = (in_data.opcode == OP_TICK);
    assign status.sweep_end = sweep_end_reg;
    assign status.walk_done = (cnt_eff == 5'd0) || (peak < $signed({3'd0, entry}))
                              || (5'(walk_idx_reg) + 5'd1 == cnt_eff);
    assign status.last_idx  = (sweep_end_reg && changed_reg) ? 2'd3 : 2'd2;

    assign wr_idx_ext = {{LIDX_W{1'b0}}, in_data.limit_index};

    // result assembly
    assign zero  = 16'(origin_y_reg) + 16'(plot_height_reg) - 16'(negpix_reg);
    assign y_min = zero - 16'(minpix_reg);
    assign y_max = zero - 16'(maxpix_reg);

    always_comb
    begin
        item = '0;
        case (cmd.emit_idx)
            2'd0:
            begin
                item.draw_kind = DRAW_ERASE;
                item.x_start   = xe_reg;
                item.y_start   = 16'(origin_y_reg);
                item.x_end     = xe_reg;
                item.y_end     = 16'(origin_y_reg) + 16'(plot_height_reg);
                item.last      = 1'b0;
            end
            2'd1:
            begin
                item.draw_kind = DRAW_DIM;
                item.x_start   = xc_reg;
                item.y_start   = zero;
                item.x_end     = xc_reg;
                item.y_end     = y_min;
                item.last      = 1'b0;
            end
            2'd2:
            begin
                item.draw_kind = DRAW_BRIGHT;
                item.x_start   = xc_reg;
                item.y_start   = y_min;
                item.x_end     = xc_reg;
                item.y_end     = y_max;
                item.last      = !(sweep_end_reg && changed_reg);
            end
            default:
            begin
                item.draw_kind = DRAW_CLEAR;
                item.x_start   = 12'(origin_x_reg) - 12'd1;
                item.y_start   = 16'(origin_y_reg) - 16'd1;
                item.x_end     = 12'(origin_x_reg) + 12'(sweep_width_reg);
                item.y_end     = 16'(origin_y_reg) + 16'(plot_height_reg);
                item.last      = 1'b1;
            end
        endcase
    end

    assign out_data = out_reg;

    // config registers and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            plot_height_reg  <= 10'd100;
            sweep_width_reg  <= 11'd100;
            range_mode_reg   <= MODE_ZERO;
            neg_floor_reg    <= -16'sd200;
            limit_count_reg  <= 4'd1;
            frame_max_reg    <= '0;
            frame_min_reg    <= '0;
            frame_count_reg  <= '0;
            sweep_max_reg    <= '0;
            sweep_min_reg    <= '0;
            column_reg       <= '0;
            range_top_reg    <= '0;
            range_bottom_reg <= '0;
            sweep_end_reg    <= 1'b0;
            changed_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:    origin_x_reg    <= cfg_data[9:0];
                    REG_ORIGIN_Y:    origin_y_reg    <= cfg_data[9:0];
                    REG_PLOT_HEIGHT: plot_height_reg <= cfg_data[9:0];
                    REG_SWEEP_WIDTH: sweep_width_reg <= cfg_data[10:0];
                    REG_RANGE_MODE:  range_mode_reg  <= cfg_data[1:0];
                    REG_NEG_FLOOR:   neg_floor_reg   <= cfg_data;
                    REG_LIMIT_COUNT: limit_count_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (cmd.accept && in_data.opcode == OP_SAMPLE
                && 32'(frame_count_reg) < FRAME_SAMPLES)
            begin
                if (frame_count_reg == 6'd0)
                begin
                    frame_max_reg <= in_data.sample_value;
                    frame_min_reg <= in_data.sample_value;
                end
                else
                begin
                    if (in_data.sample_value > frame_max_reg)
                        frame_max_reg <= in_data.sample_value;
                    if (in_data.sample_value < frame_min_reg)
                        frame_min_reg <= in_data.sample_value;
                end
                frame_count_reg <= frame_count_reg + 6'd1;
            end
            if (cmd.accept && in_data.opcode == OP_TICK)
            begin
                frame_count_reg <= '0;
                frame_max_reg   <= '0;
                frame_min_reg   <= '0;
                if (cmax > sweep_max_reg)
                    sweep_max_reg <= cmax;
                if (cmin < sweep_min_reg)
                    sweep_min_reg <= cmin;
                changed_reg <= 1'b0;
                if (11'(column_reg) + 11'd1 < width_eff)
                begin
                    column_reg    <= column_reg + 10'd1;
                    sweep_end_reg <= 1'b0;
                end
                else
                begin
                    column_reg    <= '0;
                    sweep_end_reg <= 1'b1;
                end
            end
            if (cmd.range_update)
            begin
                changed_reg   <= ({1'b0, chosen_reg} != range_top_reg);
                sweep_max_reg <= '0;
                sweep_min_reg <= '0;
                case (range_mode_reg)
                    MODE_FLOOR:
                    begin
                        range_bottom_reg <= neg_floor_reg;
                        range_top_reg    <= {1'b0, chosen_reg};
                    end
                    MODE_ZERO:
                    begin
                        range_bottom_reg <= '0;
                        range_top_reg    <= {1'b0, chosen_reg};
                    end
                    MODE_SYM:
                    begin
                        range_bottom_reg <= -$signed({1'b0, chosen_reg});
                        range_top_reg    <= {1'b0, chosen_reg};
                    end
                    default: ;
                endcase
            end
        end
    end

    // limit table: plain storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_data.opcode == OP_LIMIT
            && 32'(in_data.limit_index) < LIMIT_ENTRIES)
            limit_table[wr_idx_ext[LIDX_W-1:0]] <= in_data.limit_value;
    end

    // working registers of one tick
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_data.opcode == OP_TICK)
        begin
            cmax_reg    <= cmax_k;
            cmin_reg    <= cmin_k;
            col_inc_reg <= 11'(column_reg) + 11'd1;
            xc_reg      <= 12'(origin_x_reg) + 12'(column_reg);
        end
        if (cmd.div_load)
        begin
            rem_reg  <= div_num;
            den_reg  <= div_den;
            qneg_reg <= div_neg;
            q_reg    <= '0;
        end
        if (cmd.div_step && {1'b0, rem_reg} >= shifted)
        begin
            rem_reg <= rem_reg - shifted[26:0];
            q_reg[cmd.div_bit] <= 1'b1;
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                SEL_MOD:    xe_reg     <= 12'(origin_x_reg) + 12'(rem_reg[10:0]);
                SEL_NEGPIX: negpix_reg <= q_signed;
                SEL_MAXPIX: maxpix_reg <= q_signed;
                default:    minpix_reg <= q_signed;
            endcase
        end
        if (cmd.walk_init)
        begin
            walk_idx_reg <= '0;
            chosen_reg   <= '0;
        end
        if (cmd.walk_step)
        begin
            if (cnt_eff != 5'd0)
                chosen_reg <= entry;
            walk_idx_reg <= walk_idx_reg + 1'b1;
        end
        if (cmd.out_load)
            out_reg <= item;
    end

endmodule

// ===== rtl/swac_ctrl.sv =====
// Controller: one-hot sequencer for tick processing and result delivery.
// Depends on swac_pkg.
module swac_ctrl
    import swac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  swac_status_t status,
    output swac_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DIV_LOAD  = 7'b0000010,
        ST_DIV_ITER  = 7'b0000100,
        ST_DIV_STORE = 7'b0001000,
        ST_WALK      = 7'b0010000,
        ST_UPDATE    = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           sel_reg, sel_next;
    logic [DIV_BIT_W-1:0] bit_reg, bit_next;
    logic [1:0]           emit_reg, emit_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 can_load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign can_load  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        bit_next       = bit_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.div_sel    = sel_reg;
        cmd.div_bit    = bit_reg;
        cmd.emit_idx   = emit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.is_tick)
                begin
                    sel_next   = SEL_MOD;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                bit_next     = DIV_BIT_W'(DIV_BITS - 1);
                state_next   = ST_DIV_ITER;
            end
            ST_DIV_ITER:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg - 1'b1;
                if (bit_reg == '0)
                    state_next = ST_DIV_STORE;
            end
            ST_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                sel_next      = sel_reg + 2'd1;
                emit_next     = 2'd0;
                if (sel_reg != SEL_MINPIX)
                    state_next = ST_DIV_LOAD;
                else if (status.sweep_end)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.range_update = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    emit_next      = emit_reg + 2'd1;
                    if (emit_reg == status.last_idx)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= '0;
            bit_reg       <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            bit_reg       <= bit_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/sweep_waveform_column_autorange.sv =====
// Top level of the sweep waveform column renderer with per-sweep autoscale.
// Depends on swac_pkg, swac_ctrl and swac_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one item per
//   transfer: a sample (updates frame min/max, no result), a limit load
//   (writes one autoscale table entry, no result) or a frame tick.
//   in_stall stays low for samples and limit loads.
//   A tick raises in_stall while it works: four passes of the shared
//   restoring divider (column wrap, zero line, max and min pixel), each
//   a load, one step per quotient bit and a store, plus at a sweep end
//   a walk of the limit table and a range update.
//   The tick then delivers three draw commands (erase, dim, bright) and a
//   clear rectangle when the range changed, one per cycle through the
//   output register unless it is stalled; the last one carries last = 1.
//   Output channel (out_valid / out_stall / out_data) holds a stalled result
//   unchanged; a stall only delays delivery and the next input is taken
//   once the final result of the tick sits in the output register.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; write only while the block is idle.
//   Reset (rst_n low, asynchronous) restores register defaults, clears
//   frame and sweep state, sets the range to zero and empties the output.
//   Limit entries hold nothing valid until loaded.
module sweep_waveform_column_autorange
    import swac_pkg::*;
#(
    parameter int LIMIT_ENTRIES = LIMIT_ENTRIES_DEF,
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    swac_cmd_t    cmd;
    swac_status_t status;

    // Config writes go straight into the config registers, so the port never pushes back.
    assign cfg_ready = 1'b1;

    swac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    swac_datapath #(
        .LIMIT_ENTRIES (LIMIT_ENTRIES),
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/swac_checker.sv =====
// Port-level checker for the sweep waveform column renderer, bound to the
// top level. Depends on swac_pkg.
module swac_checker
    import swac_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A tick transfer must hold off the next input while it computes.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.opcode == OP_TICK |=> in_stall)
        else $error("tick did not stall input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.draw_kind == DRAW_CLEAR |-> out_data.last)
        else $error("clear rectangle not final");

    a_early_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.draw_kind == DRAW_ERASE
                      || out_data.draw_kind == DRAW_DIM) |-> !out_data.last)
        else $error("erase or dim marked final");

endmodule

bind sweep_waveform_column_autorange swac_checker u_swac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
